// ===== rtl/mts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types, codes and default sizes of the markov transition sampler.
// ----------------------------------------------------------------------------
package mts_pkg;

    // default sizes, handed to the top level parameters
    localparam int NUM_STATES_DEF      = 16;
    localparam int NUM_STRATEGIES_DEF  = 4;
    localparam int MAX_TRANSITIONS_DEF = 8;
    localparam int PROB_FRAC_BITS_DEF  = 16;

    // fixed field widths
    localparam int PROB_W    = 17;
    localparam int CUTOFF_W  = 16;
    localparam int SECONDS_W = 32;
    localparam int PROD_W    = SECONDS_W + CUTOFF_W;

    typedef logic [3:0]           state_idx_t;
    typedef logic [PROB_W-1:0]    prob_t;
    typedef logic [CUTOFF_W-1:0]  frac_t;
    typedef logic [SECONDS_W-1:0] seconds_t;

    // operation codes of an input word
    typedef enum logic [1:0] {
        OP_SAMPLE   = 2'd0,
        OP_WR_ENTRY = 2'd1,
        OP_WR_COUNT = 2'd2,
        OP_WR_DWELL = 2'd3
    } opcode_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_CHOSEN = 2'd0,
        STAT_NONE   = 2'd1,
        STAT_ACK    = 2'd2
    } status_t;

    // dwell kinds
    typedef enum logic [1:0] {
        KIND_FIXED   = 2'd0,
        KIND_FOREVER = 2'd1,
        KIND_UNIFORM = 2'd2,
        KIND_ZERO    = 2'd3
    } kind_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COUNT,
        ST_WALK,
        ST_DWELL_RD,
        ST_DWELL_WAIT,
        ST_DONE
    } mts_state_t;

    // one transition entry
    typedef struct packed {
        prob_t      prob;
        state_idx_t target;
    } entry_t;

    // dwell definition of one state
    typedef struct packed {
        kind_t    kind;
        seconds_t low;
        seconds_t high;
    } dwell_def_t;

    // table write enables
    typedef struct packed {
        logic entry;
        logic count;
        logic dwell;
    } tbl_we_t;

endpackage

// ===== rtl/markov_transition_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markov_transition_sampler
// Markov transition sampler with inverse-cdf selection over stored tables.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_ready) takes one word per operation: a
// sample, a transition entry write, a set count write or a dwell write.
// Result channel (result_valid/result_ready) returns exactly one word per
// input word, in order.
// One word is in work at a time. A write goes to the done state and loads
// the result register as soon as it is free; the next word may enter once
// the result is loaded. A sample reads the set count, then walks the stored
// transitions one slot a cycle through the entry memory read port, then
// reads the dwell definition and runs the dwell unit. A sample with no hit,
// an empty set or a set out of range returns a no-transition result.
// After reset a clearing pass over all NUM_STATES * NUM_STRATEGIES sets
// zeroes the set counts and sets every dwell to zero time; item_ready stays
// low meanwhile. One finished result waits in the output register; a new
// word is taken while it waits, and the next result holds until the
// receiver takes it.
// ----------------------------------------------------------------------------
module markov_transition_sampler #(
    parameter int NUM_STATES      = mts_pkg::NUM_STATES_DEF,
    parameter int NUM_STRATEGIES  = mts_pkg::NUM_STRATEGIES_DEF,
    parameter int MAX_TRANSITIONS = mts_pkg::MAX_TRANSITIONS_DEF,
    parameter int PROB_FRAC_BITS  = mts_pkg::PROB_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [1:0]          opcode,
    input  mts_pkg::state_idx_t current_state,
    input  logic [1:0]          strategy,
    input  logic [2:0]          slot,
    input  mts_pkg::prob_t      probability,
    input  mts_pkg::state_idx_t target_value,
    input  logic [1:0]          dwell_kind,
    input  mts_pkg::seconds_t   min_seconds,
    input  mts_pkg::seconds_t   max_seconds,
    input  mts_pkg::frac_t      random_cutoff,
    input  mts_pkg::frac_t      random_fraction,
    output logic                result_valid,
    input  logic                result_ready,
    output mts_pkg::state_idx_t chosen_state,
    output mts_pkg::seconds_t   dwell_seconds,
    output logic [1:0]          status
);
    import mts_pkg::*;

    localparam int SET_DEPTH   = NUM_STATES * NUM_STRATEGIES;
    localparam int ENTRY_DEPTH = SET_DEPTH * MAX_TRANSITIONS;
    localparam int SET_AW      = $clog2(SET_DEPTH);
    localparam int ENTRY_AW    = $clog2(ENTRY_DEPTH);
    localparam int STATE_AW    = $clog2(NUM_STATES);

    tbl_we_t             tbl_we;
    logic [ENTRY_AW-1:0] entry_waddr, entry_raddr;
    entry_t              entry_wdata, entry_q;
    logic [SET_AW-1:0]   count_waddr, count_raddr;
    state_idx_t          count_wdata, count_q;
    logic [STATE_AW-1:0] dwell_waddr, dwell_raddr;
    dwell_def_t          dwell_wdata, dwell_q;
    logic                dw_start, dw_done;
    dwell_def_t          dw_def;
    frac_t               dw_frac;
    seconds_t            dw_seconds;

    // sequencer
    mts_ctrl #(
        .NUM_STATES      (NUM_STATES),
        .NUM_STRATEGIES  (NUM_STRATEGIES),
        .MAX_TRANSITIONS (MAX_TRANSITIONS),
        .PROB_FRAC_BITS  (PROB_FRAC_BITS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .opcode          (opcode),
        .current_state   (current_state),
        .strategy        (strategy),
        .slot            (slot),
        .probability     (probability),
        .target_value    (target_value),
        .dwell_kind      (dwell_kind),
        .min_seconds     (min_seconds),
        .max_seconds     (max_seconds),
        .random_cutoff   (random_cutoff),
        .random_fraction (random_fraction),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .chosen_state    (chosen_state),
        .dwell_seconds   (dwell_seconds),
        .status          (status),
        .tbl_we          (tbl_we),
        .entry_waddr     (entry_waddr),
        .entry_wdata     (entry_wdata),
        .entry_raddr     (entry_raddr),
        .entry_q         (entry_q),
        .count_waddr     (count_waddr),
        .count_wdata     (count_wdata),
        .count_raddr     (count_raddr),
        .count_q         (count_q),
        .dwell_waddr     (dwell_waddr),
        .dwell_wdata     (dwell_wdata),
        .dwell_raddr     (dwell_raddr),
        .dwell_q         (dwell_q),
        .dw_start        (dw_start),
        .dw_def          (dw_def),
        .dw_frac         (dw_frac),
        .dw_done         (dw_done),
        .dw_seconds      (dw_seconds)
    );

    // table memories
    mts_tables #(
        .NUM_STATES      (NUM_STATES),
        .NUM_STRATEGIES  (NUM_STRATEGIES),
        .MAX_TRANSITIONS (MAX_TRANSITIONS)
    ) u_tables (
        .clk         (clk),
        .we          (tbl_we),
        .entry_waddr (entry_waddr),
        .entry_wdata (entry_wdata),
        .entry_raddr (entry_raddr),
        .entry_q     (entry_q),
        .count_waddr (count_waddr),
        .count_wdata (count_wdata),
        .count_raddr (count_raddr),
        .count_q     (count_q),
        .dwell_waddr (dwell_waddr),
        .dwell_wdata (dwell_wdata),
        .dwell_raddr (dwell_raddr),
        .dwell_q     (dwell_q)
    );

    // dwell time unit
    mts_dwell u_dwell (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (dw_start),
        .def     (dw_def),
        .frac    (dw_frac),
        .done    (dw_done),
        .seconds (dw_seconds)
    );

endmodule

// ===== rtl/mts_tables.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_tables
// Transition entry, set count and dwell definition memories, one write and
// one registered read port each.
// ----------------------------------------------------------------------------
module mts_tables #(
    parameter int NUM_STATES      = mts_pkg::NUM_STATES_DEF,
    parameter int NUM_STRATEGIES  = mts_pkg::NUM_STRATEGIES_DEF,
    parameter int MAX_TRANSITIONS = mts_pkg::MAX_TRANSITIONS_DEF,
    localparam int SET_DEPTH   = NUM_STATES * NUM_STRATEGIES,
    localparam int ENTRY_DEPTH = SET_DEPTH * MAX_TRANSITIONS,
    localparam int SET_AW      = $clog2(SET_DEPTH),
    localparam int ENTRY_AW    = $clog2(ENTRY_DEPTH),
    localparam int STATE_AW    = $clog2(NUM_STATES)
) (
    input  logic                 clk,
    input  mts_pkg::tbl_we_t     we,
    input  logic [ENTRY_AW-1:0]  entry_waddr,
    input  mts_pkg::entry_t      entry_wdata,
    input  logic [ENTRY_AW-1:0]  entry_raddr,
    output mts_pkg::entry_t      entry_q,
    input  logic [SET_AW-1:0]    count_waddr,
    input  mts_pkg::state_idx_t  count_wdata,
    input  logic [SET_AW-1:0]    count_raddr,
    output mts_pkg::state_idx_t  count_q,
    input  logic [STATE_AW-1:0]  dwell_waddr,
    input  mts_pkg::dwell_def_t  dwell_wdata,
    input  logic [STATE_AW-1:0]  dwell_raddr,
    output mts_pkg::dwell_def_t  dwell_q
);
    import mts_pkg::*;

    entry_t     entry_mem [ENTRY_DEPTH];
    state_idx_t count_mem [SET_DEPTH];
    dwell_def_t dwell_mem [NUM_STATES];

    // transition entries
    always_ff @(posedge clk)
    begin
        if (we.entry)
        begin
            entry_mem[entry_waddr] <= entry_wdata;
        end
        entry_q <= entry_mem[entry_raddr];
    end

    // transition counts per set
    always_ff @(posedge clk)
    begin
        if (we.count)
        begin
            count_mem[count_waddr] <= count_wdata;
        end
        count_q <= count_mem[count_raddr];
    end

    // dwell definitions per state
    always_ff @(posedge clk)
    begin
        if (we.dwell)
        begin
            dwell_mem[dwell_waddr] <= dwell_wdata;
        end
        dwell_q <= dwell_mem[dwell_raddr];
    end

endmodule

// ===== rtl/mts_dwell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_dwell
// Three-stage dwell time unit: span, span times fraction, offset and select.
// ----------------------------------------------------------------------------
module mts_dwell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mts_pkg::dwell_def_t def,
    input  mts_pkg::frac_t      frac,
    output logic                done,
    output mts_pkg::seconds_t   seconds
);
    import mts_pkg::*;

    logic              v1_reg, v2_reg, v3_reg;
    kind_t             kind1_reg, kind2_reg;
    seconds_t          low1_reg, low2_reg;
    seconds_t          span1_reg;
    frac_t             frac1_reg;
    logic [PROD_W-1:0] prod2_reg;
    seconds_t          sec3_reg;
    seconds_t          span_next;
    seconds_t          sec_next;

    // span clamps to zero when the upper bound is below the lower one
    always_comb
    begin
        span_next = (def.high >= def.low) ? (def.high - def.low) : '0;
    end

    // final select per kind
    always_comb
    begin
        case (kind2_reg)
            KIND_FIXED:   sec_next = low2_reg;
            KIND_FOREVER: sec_next = '1;
            KIND_UNIFORM: sec_next = low2_reg + prod2_reg[PROD_W-1:CUTOFF_W];
            default:      sec_next = '0;
        endcase
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        kind1_reg <= def.kind;
        low1_reg  <= def.low;
        span1_reg <= span_next;
        frac1_reg <= frac;
        kind2_reg <= kind1_reg;
        low2_reg  <= low1_reg;
        prod2_reg <= span1_reg * frac1_reg;
        sec3_reg  <= sec_next;
    end

    assign done    = v3_reg;
    assign seconds = sec3_reg;

endmodule

// ===== rtl/mts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer: clearing pass, table writes, set walk with running sum, dwell
// request and the result register.
// ----------------------------------------------------------------------------
module mts_ctrl #(
    parameter int NUM_STATES      = mts_pkg::NUM_STATES_DEF,
    parameter int NUM_STRATEGIES  = mts_pkg::NUM_STRATEGIES_DEF,
    parameter int MAX_TRANSITIONS = mts_pkg::MAX_TRANSITIONS_DEF,
    parameter int PROB_FRAC_BITS  = mts_pkg::PROB_FRAC_BITS_DEF,
    localparam int SET_DEPTH   = NUM_STATES * NUM_STRATEGIES,
    localparam int ENTRY_DEPTH = SET_DEPTH * MAX_TRANSITIONS,
    localparam int SET_AW      = $clog2(SET_DEPTH),
    localparam int ENTRY_AW    = $clog2(ENTRY_DEPTH),
    localparam int STATE_AW    = $clog2(NUM_STATES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input channel
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [1:0]           opcode,
    input  mts_pkg::state_idx_t  current_state,
    input  logic [1:0]           strategy,
    input  logic [2:0]           slot,
    input  mts_pkg::prob_t       probability,
    input  mts_pkg::state_idx_t  target_value,
    input  logic [1:0]           dwell_kind,
    input  mts_pkg::seconds_t    min_seconds,
    input  mts_pkg::seconds_t    max_seconds,
    input  mts_pkg::frac_t       random_cutoff,
    input  mts_pkg::frac_t       random_fraction,
    // result channel
    output logic                 result_valid,
    input  logic                 result_ready,
    output mts_pkg::state_idx_t  chosen_state,
    output mts_pkg::seconds_t    dwell_seconds,
    output logic [1:0]           status,
    // tables
    output mts_pkg::tbl_we_t     tbl_we,
    output logic [ENTRY_AW-1:0]  entry_waddr,
    output mts_pkg::entry_t      entry_wdata,
    output logic [ENTRY_AW-1:0]  entry_raddr,
    input  mts_pkg::entry_t      entry_q,
    output logic [SET_AW-1:0]    count_waddr,
    output mts_pkg::state_idx_t  count_wdata,
    output logic [SET_AW-1:0]    count_raddr,
    input  mts_pkg::state_idx_t  count_q,
    output logic [STATE_AW-1:0]  dwell_waddr,
    output mts_pkg::dwell_def_t  dwell_wdata,
    output logic [STATE_AW-1:0]  dwell_raddr,
    input  mts_pkg::dwell_def_t  dwell_q,
    // dwell unit
    output logic                 dw_start,
    output mts_pkg::dwell_def_t  dw_def,
    output mts_pkg::frac_t       dw_frac,
    input  logic                 dw_done,
    input  mts_pkg::seconds_t    dw_seconds
);
    import mts_pkg::*;

    localparam int CNT_W = $clog2(MAX_TRANSITIONS + 1);
    localparam int SUM_W = PROB_W + CNT_W;
    localparam int LHS_W = CUTOFF_W + PROB_FRAC_BITS;
    localparam int RHS_W = SUM_W + CUTOFF_W;
    localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    mts_state_t        state_reg, state_next;
    logic [SET_AW-1:0] clr_idx_reg, clr_idx_next;
    logic              result_valid_reg, result_valid_next;
    logic [SET_AW-1:0] set_reg, set_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    frac_t             cutoff_reg, cutoff_next;
    frac_t             frac_reg, frac_next;
    logic              tgt_ok_reg, tgt_ok_next;
    state_idx_t        res_state_reg, res_state_next;
    seconds_t          res_dwell_reg, res_dwell_next;
    status_t           res_status_reg, res_status_next;
    state_idx_t        chosen_state_reg;
    seconds_t          dwell_seconds_reg;
    status_t           status_reg;

    logic              item_fire;
    logic              st_ok, in_set, slot_ok;
    logic [SET_AW-1:0] set_in;
    logic [CNT_W-1:0]  n_sat;
    logic [CNT_W-1:0]  idx_inc;
    logic [SUM_W-1:0]  sum_walk;
    logic [CMP_W-1:0]  lhs, rhs;
    logic              hit;
    logic              result_load;
    logic              clear_dwell;

    // decode of the input word
    always_comb
    begin
        item_fire = item_valid && item_ready;
        st_ok     = 32'(current_state) < NUM_STATES;
        in_set    = st_ok && (32'(strategy) < NUM_STRATEGIES);
        slot_ok   = 32'(slot) < MAX_TRANSITIONS;
        set_in    = SET_AW'(current_state) * SET_AW'(NUM_STRATEGIES) + SET_AW'(strategy);
    end

    // walk arithmetic: saturated count, running sum and exact cutoff compare
    always_comb
    begin
        n_sat    = (32'(count_q) > MAX_TRANSITIONS) ? CNT_W'(MAX_TRANSITIONS)
                                                    : CNT_W'(count_q);
        idx_inc  = idx_reg + 1'b1;
        sum_walk = sum_reg + SUM_W'(entry_q.prob);
        lhs      = CMP_W'(cutoff_reg) << PROB_FRAC_BITS;
        rhs      = CMP_W'(sum_walk) << CUTOFF_W;
        hit      = lhs <= rhs;
    end

    // table addresses and write data
    always_comb
    begin
        entry_waddr = ENTRY_AW'(set_in) * ENTRY_AW'(MAX_TRANSITIONS) + ENTRY_AW'(slot);
        entry_wdata = '{prob: probability, target: target_value};
        entry_raddr = ENTRY_AW'(set_reg) * ENTRY_AW'(MAX_TRANSITIONS)
                    + ((state_reg == ST_COUNT) ? '0 : ENTRY_AW'(idx_inc));
        count_raddr = set_in;
        dwell_raddr = STATE_AW'(entry_q.target);
        clear_dwell = 32'(clr_idx_reg) < NUM_STATES;
        if (state_reg == ST_CLEAR)
        begin
            count_waddr = clr_idx_reg;
            count_wdata = '0;
            dwell_waddr = STATE_AW'(clr_idx_reg);
            dwell_wdata = '{kind: KIND_ZERO, low: '0, high: '0};
        end
        else
        begin
            count_waddr = set_in;
            count_wdata = target_value;
            dwell_waddr = STATE_AW'(current_state);
            dwell_wdata = '{kind: kind_t'(dwell_kind), low: min_seconds, high: max_seconds};
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == SET_AW'(SET_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    state_next = (opcode == OP_SAMPLE && in_set) ? ST_COUNT : ST_DONE;
                end
            end
            ST_COUNT:
            begin
                state_next = (n_sat == '0) ? ST_DONE : ST_WALK;
            end
            ST_WALK:
            begin
                if (hit)
                begin
                    state_next = ST_DWELL_RD;
                end
                else if (idx_inc == cnt_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DWELL_RD:
            begin
                state_next = ST_DWELL_WAIT;
            end
            ST_DWELL_WAIT:
            begin
                if (dw_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (result_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        item_ready   = (state_reg == ST_IDLE);
        tbl_we.entry = item_fire && (opcode == OP_WR_ENTRY) && in_set && slot_ok;
        tbl_we.count = ((state_reg == ST_CLEAR))
                    || (item_fire && (opcode == OP_WR_COUNT) && in_set);
        tbl_we.dwell = ((state_reg == ST_CLEAR) && clear_dwell)
                    || (item_fire && (opcode == OP_WR_DWELL) && st_ok);
        dw_start     = (state_reg == ST_DWELL_RD);
        dw_def       = '{kind: tgt_ok_reg ? dwell_q.kind : KIND_ZERO,
                         low: dwell_q.low, high: dwell_q.high};
        dw_frac      = frac_reg;
        result_load  = (state_reg == ST_DONE) && (!result_valid_reg || result_ready);
    end

    // datapath next values
    always_comb
    begin
        clr_idx_next    = clr_idx_reg;
        set_next        = set_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        cutoff_next     = cutoff_reg;
        frac_next       = frac_reg;
        tgt_ok_next     = tgt_ok_reg;
        res_state_next  = res_state_reg;
        res_dwell_next  = res_dwell_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    set_next        = set_in;
                    cutoff_next     = random_cutoff;
                    frac_next       = random_fraction;
                    res_state_next  = '0;
                    res_dwell_next  = '0;
                    res_status_next = (opcode == OP_SAMPLE) ? STAT_NONE : STAT_ACK;
                end
            end
            ST_COUNT:
            begin
                cnt_next = n_sat;
                idx_next = '0;
                sum_next = '0;
            end
            ST_WALK:
            begin
                sum_next = sum_walk;
                idx_next = idx_inc;
                if (hit)
                begin
                    res_state_next = entry_q.target;
                    tgt_ok_next    = 32'(entry_q.target) < NUM_STATES;
                end
            end
            ST_DWELL_WAIT:
            begin
                if (dw_done)
                begin
                    res_dwell_next  = dw_seconds;
                    res_status_next = STAT_CHOSEN;
                end
            end
            default:
            begin
            end
        endcase
    end

    // result valid
    always_comb
    begin
        if (result_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_idx_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_idx_reg      <= clr_idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        set_reg        <= set_next;
        cnt_reg        <= cnt_next;
        idx_reg        <= idx_next;
        sum_reg        <= sum_next;
        cutoff_reg     <= cutoff_next;
        frac_reg       <= frac_next;
        tgt_ok_reg     <= tgt_ok_next;
        res_state_reg  <= res_state_next;
        res_dwell_reg  <= res_dwell_next;
        res_status_reg <= res_status_next;
        if (result_load)
        begin
            chosen_state_reg  <= res_state_reg;
            dwell_seconds_reg <= res_dwell_reg;
            status_reg        <= res_status_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign chosen_state  = chosen_state_reg;
    assign dwell_seconds = dwell_seconds_reg;
    assign status        = status_reg;

endmodule

// ===== rtl/mts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks of the markov transition sampler, bound to the top level.
// ----------------------------------------------------------------------------
module mts_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                result_valid,
    input logic                result_ready,
    input mts_pkg::state_idx_t chosen_state,
    input mts_pkg::seconds_t   dwell_seconds,
    input logic [1:0]          status
);
    import mts_pkg::*;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(chosen_state) && $stable(dwell_seconds)
            && $stable(status))
    else $error("stalled result word changed");

    // one word in work at a time: ready drops after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
    else $error("input ready stayed high after an accept");

    // write acknowledge carries no state and no dwell
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == STAT_ACK) |->
            (chosen_state == '0) && (dwell_seconds == '0))
    else $error("write acknowledge with nonzero payload");

    // no transition carries no state and no dwell
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == STAT_NONE) |->
            (chosen_state == '0) && (dwell_seconds == '0))
    else $error("no-transition result with nonzero payload");

endmodule

bind markov_transition_sampler mts_checker u_mts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .chosen_state  (chosen_state),
    .dwell_seconds (dwell_seconds),
    .status        (status)
);
